// File: rtl/scesw_pkg.sv
// Package for the signal change, edge, step and slope watcher.
// Holds widths, register indexes and the sequencer state type.
// No dependencies; every other file of the block imports it.
`default_nettype none
package scesw_pkg;

	localparam int SW      = 16;           // sample width
	localparam int TW      = 24;           // tap tick counter width
	localparam int NTRIG   = 9;
	localparam int SLW     = SW + 16;      // slew value, 16 fraction bits
	localparam int DFW     = SLW + 1;      // filter difference and per-tick change
	localparam int MW      = (TW > 17) ? TW : 17;
	localparam int AW      = DFW + MW;     // serial product accumulator
	localparam int CNTN    = (MW > SW) ? MW : SW;
	localparam int CW      = $clog2(CNTN);
	localparam int AD_W    = 5;

	localparam logic [2:0] REG_HYST  = 3'd0;
	localparam logic [2:0] REG_EDGE  = 3'd1;
	localparam logic [2:0] REG_STEP  = 3'd2;
	localparam logic [2:0] REG_THR   = 3'd3;
	localparam logic [2:0] REG_COEF  = 3'd4;
	localparam logic [2:0] REG_RATE  = 3'd5;
	localparam logic [2:0] REG_TLEN  = 3'd6;
	localparam logic [2:0] REG_TAPEN = 3'd7;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_MUL1 = 5'b00010,
		ST_MUL2 = 5'b00100,
		ST_DIV  = 5'b01000,
		ST_FIN  = 5'b10000
	} state_t;

endpackage
`default_nettype wire

// File: rtl/scesw_in_if.sv
// Input channel of the watcher: one sample and the tap gate level per item.
// Depends on scesw_pkg for the sample width.
`default_nettype none
interface scesw_in_if import scesw_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic signed [SW-1:0] sample;
	logic                 tap_gate;

	modport source(output valid, sample, tap_gate, input ready);
	modport sink(input valid, sample, tap_gate, output ready);
endinterface
`default_nettype wire

// File: rtl/scesw_out_if.sv
// Result channel of the watcher: slope, moving gates and trigger levels.
// Depends on scesw_pkg for the trigger count.
`default_nettype none
interface scesw_out_if import scesw_pkg::*; ();
	logic              valid;
	logic              ready;
	logic signed [31:0] slope;
	logic              moving;
	logic              moving_up;
	logic              moving_down;
	logic [NTRIG-1:0]  trigger_levels;

	modport source(output valid, slope, moving, moving_up, moving_down, trigger_levels,
		input ready);
	modport sink(input valid, slope, moving, moving_up, moving_down, trigger_levels,
		output ready);
endinterface
`default_nettype wire

// File: rtl/signal_change_edge_step_slope_watch.sv
// Top level of the signal change, edge, step and slope watcher.
// Depends on scesw_pkg, scesw_in_if and scesw_out_if.
//
// Each item is one tick: a signed sample and a tap gate level. The block
// answers with one result item holding the slope, the moving gates and nine
// trigger levels. A shift-and-add multiplier works one bit per cycle,
// first through the 17-bit filter coefficient, then through the 24-bit slope
// scale, and a restoring divider finds the step compartment one quotient bit
// per cycle. The user must write registers over the APB port only while the
// block is idle; the block itself does not enforce it.
`default_nettype none
module signal_change_edge_step_slope_watch import scesw_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	scesw_in_if.sink              sample_ch,
	scesw_out_if.source           result_ch,
	input  wire logic             psel,
	input  wire logic             penable,
	input  wire logic             pwrite,
	input  wire logic [AD_W-1:0]  paddr,
	input  wire logic [31:0]      pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	// Configuration registers
	logic [15:0] hyst_q, edge_q, step_q, rate_q, tlen_q;
	logic [30:0] thr_q;
	logic [16:0] coef_q;
	logic        tapen_q;

	// Detector state
	state_t                 state_q;
	logic                   init_q, first_q;
	logic signed [SW-1:0]   s_q, kept_q, prev_q;
	logic signed [SW:0]     comp_prev_q;
	logic signed [SLW-1:0]  slew_q;
	logic                   gate_last_q, tap_seen_q;
	logic [TW-1:0]          ticks_q, period_q;
	logic [15:0]            cd_q [NTRIG];

	// Serial arithmetic
	logic signed [AW-1:0]   acc_q, mc_q;
	logic [MW-1:0]          mpl_q;
	logic [CW-1:0]          cnt_q;
	logic                   neg_q, half_q;
	logic [SW-1:0]          dq_q;
	logic [16:0]            rem_q;
	logic signed [31:0]     slope_q;

	// Result register
	logic                   ov_q;
	logic signed [31:0]     o_slope_q;
	logic                   o_mov_q, o_up_q, o_dn_q;
	logic [NTRIG-1:0]       o_lev_q;

	logic                   wr_en, acc_in, fin_go;
	logic signed [SLW-1:0]  target, slew_base;
	logic signed [DFW-1:0]  fdiff, delta;
	logic [DFW-1:0]         delta_mag;
	logic signed [AW-1:0]   acc_n;
	logic [AW-1:0]          q_sh;
	logic signed [31:0]     slope_n;
	logic [TW-1:0]          ticks_inc;
	logic [16:0]            coef_c, r_next;
	logic [SW:0]            s_abs_w;
	logic signed [SW:0]     comp, dk, de;
	logic [SW:0]            dk_mag, de_mag;
	logic [NTRIG-1:0]       fire;
	logic [15:0]            tlen_eff;
	logic [15:0]            cd_n [NTRIG];
	logic [NTRIG-1:0]       lev_n;
	logic                   up_n, dn_n;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_comb begin
		case (paddr[4:2])
			REG_HYST:  prdata = {16'd0, hyst_q};
			REG_EDGE:  prdata = {16'd0, edge_q};
			REG_STEP:  prdata = {16'd0, step_q};
			REG_THR:   prdata = {1'b0, thr_q};
			REG_COEF:  prdata = {15'd0, coef_q};
			REG_RATE:  prdata = {16'd0, rate_q};
			REG_TLEN:  prdata = {16'd0, tlen_q};
			REG_TAPEN: prdata = {31'd0, tapen_q};
			default:   prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hyst_q  <= '0;
			edge_q  <= '0;
			step_q  <= '0;
			thr_q   <= '0;
			coef_q  <= 17'h10000;
			rate_q  <= 16'd1000;
			tlen_q  <= 16'd10;
			tapen_q <= 1'b0;
		end else if (wr_en) begin
			case (paddr[4:2])
				REG_HYST:  hyst_q  <= pwdata[15:0];
				REG_EDGE:  edge_q  <= pwdata[15:0];
				REG_STEP:  step_q  <= pwdata[15:0];
				REG_THR:   thr_q   <= pwdata[30:0];
				REG_COEF:  coef_q  <= pwdata[16:0];
				REG_RATE:  rate_q  <= pwdata[15:0];
				REG_TLEN:  tlen_q  <= pwdata[15:0];
				REG_TAPEN: tapen_q <= pwdata[0];
				default:   ;
			endcase
		end
	end

	assign sample_ch.ready = (state_q == ST_IDLE);
	assign acc_in = sample_ch.valid && (state_q == ST_IDLE);

	// Accept-time arithmetic. On the first item the filter starts at the target.
	assign target    = {sample_ch.sample, 16'd0};
	assign slew_base = init_q ? slew_q : target;
	assign fdiff     = DFW'(target) - DFW'(slew_base);
	assign ticks_inc = (ticks_q == {TW{1'b1}}) ? ticks_q : ticks_q + 1'b1;
	assign coef_c    = coef_q[16] ? 17'h10000 : coef_q;

	// One shift-and-add step, shared by both products.
	assign acc_n     = mpl_q[0] ? acc_q + mc_q : acc_q;
	assign delta     = DFW'(acc_n >>> 16);
	assign delta_mag = delta[DFW-1] ? DFW'(-delta) : DFW'(delta);

	// Truncate the magnitude product, then saturate to 32 bits.
	assign q_sh = half_q ? AW'(acc_n >> 17) : AW'(acc_n >> 16);
	always_comb begin
		if (neg_q) begin
			if (q_sh[AW-1:32] != '0 || (q_sh[31] && q_sh[30:0] != '0))
				slope_n = 32'sh8000_0000;
			else
				slope_n = -$signed(q_sh[31:0]);
		end else begin
			if (q_sh[AW-1:31] != '0)
				slope_n = 32'sh7FFF_FFFF;
			else
				slope_n = $signed(q_sh[31:0]);
		end
	end

	assign r_next  = {rem_q[15:0], dq_q[SW-1]};
	assign s_abs_w = s_q[SW-1] ? (SW+1)'(-$signed({s_q[SW-1], s_q})) : (SW+1)'(s_q);

	// Floor division: a negative dividend with a remainder rounds one further down.
	always_comb begin
		if (s_q[SW-1])
			comp = -$signed({1'b0, dq_q}) - $signed({{SW{1'b0}}, (rem_q != '0)});
		else
			comp = $signed({1'b0, dq_q});
	end

	assign dk     = $signed({s_q[SW-1], s_q}) - $signed({kept_q[SW-1], kept_q});
	assign de     = $signed({s_q[SW-1], s_q}) - $signed({prev_q[SW-1], prev_q});
	assign dk_mag = dk[SW] ? (SW+1)'(-dk) : (SW+1)'(dk);
	assign de_mag = de[SW] ? (SW+1)'(-de) : (SW+1)'(de);

	always_comb begin
		fire = '0;
		if (!first_q) begin
			if (dk_mag > (SW+1)'(hyst_q)) begin
				fire[0] = 1'b1;
				fire[1] = !dk[SW];
				fire[2] = dk[SW];
			end
			if (de != '0 && de_mag >= (SW+1)'(edge_q)) begin
				fire[3] = 1'b1;
				fire[4] = !de[SW];
				fire[5] = de[SW];
			end
			if (step_q != '0 && comp != comp_prev_q) begin
				fire[6] = 1'b1;
				fire[7] = comp > comp_prev_q;
				fire[8] = comp < comp_prev_q;
			end
		end
	end

	assign tlen_eff = (tlen_q == '0) ? 16'd1 : tlen_q;
	always_comb begin
		for (int i = 0; i < NTRIG; i++) begin
			cd_n[i]  = fire[i] ? tlen_eff : cd_q[i];
			lev_n[i] = (cd_n[i] != '0);
		end
	end

	assign up_n   = $signed({slope_q[31], slope_q}) > $signed({2'b00, thr_q});
	assign dn_n   = $signed({slope_q[31], slope_q}) < -$signed({2'b00, thr_q});
	assign fin_go = (state_q == ST_FIN) && (!ov_q || result_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			init_q      <= 1'b0;
			first_q     <= 1'b0;
			kept_q      <= '0;
			prev_q      <= '0;
			comp_prev_q <= '0;
			slew_q      <= '0;
			gate_last_q <= 1'b0;
			tap_seen_q  <= 1'b0;
			ticks_q     <= '0;
			period_q    <= '0;
			ov_q        <= 1'b0;
			cnt_q       <= '0;
			for (int i = 0; i < NTRIG; i++) cd_q[i] <= '0;
		end else begin
			if (ov_q && result_ch.ready) ov_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (acc_in) begin
						s_q <= sample_ch.sample;
						for (int i = 0; i < NTRIG; i++)
							if (cd_q[i] != '0) cd_q[i] <= cd_q[i] - 1'b1;
						ticks_q <= ticks_inc;
						if (tapen_q) begin
							gate_last_q <= sample_ch.tap_gate;
							if (sample_ch.tap_gate && !gate_last_q) begin
								if (tap_seen_q) period_q <= ticks_inc;
								ticks_q    <= '0;
								tap_seen_q <= 1'b1;
							end
						end
						if (!init_q) begin
							kept_q <= sample_ch.sample;
							prev_q <= sample_ch.sample;
						end
						slew_q  <= slew_base;
						mc_q    <= AW'(fdiff);
						acc_q   <= '0;
						mpl_q   <= MW'(coef_c);
						cnt_q   <= '0;
						first_q <= !init_q;
						init_q  <= 1'b1;
						state_q <= ST_MUL1;
					end
				end
				ST_MUL1: begin
					acc_q <= acc_n;
					mc_q  <= mc_q <<< 1;
					mpl_q <= mpl_q >> 1;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(16)) begin
						slew_q  <= slew_q + SLW'(delta);
						neg_q   <= delta[DFW-1];
						mc_q    <= AW'({1'b0, delta_mag});
						acc_q   <= '0;
						mpl_q   <= (tapen_q && period_q != '0) ? MW'(period_q) : MW'(rate_q);
						half_q  <= tapen_q && (period_q == '0);
						cnt_q   <= '0;
						state_q <= ST_MUL2;
					end
				end
				ST_MUL2: begin
					acc_q <= acc_n;
					mc_q  <= mc_q <<< 1;
					mpl_q <= mpl_q >> 1;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(MW - 1)) begin
						slope_q <= slope_n;
						dq_q    <= s_abs_w[SW-1:0];
						rem_q   <= '0;
						cnt_q   <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (r_next >= {1'b0, step_q}) begin
						rem_q <= r_next - {1'b0, step_q};
						dq_q  <= {dq_q[SW-2:0], 1'b1};
					end else begin
						rem_q <= r_next;
						dq_q  <= {dq_q[SW-2:0], 1'b0};
					end
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(SW - 1)) state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (fin_go) begin
						for (int i = 0; i < NTRIG; i++) cd_q[i] <= cd_n[i];
						if (first_q || fire[0]) kept_q <= s_q;
						prev_q <= s_q;
						if (step_q != '0 && (first_q || fire[6])) comp_prev_q <= comp;
						ov_q      <= 1'b1;
						o_slope_q <= slope_q;
						o_up_q    <= up_n;
						o_dn_q    <= dn_n;
						o_mov_q   <= up_n || dn_n;
						o_lev_q   <= lev_n;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign result_ch.valid          = ov_q;
	assign result_ch.slope          = o_slope_q;
	assign result_ch.moving         = o_mov_q;
	assign result_ch.moving_up      = o_up_q;
	assign result_ch.moving_down    = o_dn_q;
	assign result_ch.trigger_levels = o_lev_q;

	a_gates_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		result_ch.valid |-> !(result_ch.moving_up && result_ch.moving_down))
		else $error("moving up and down both set");

	a_moving_is_or: assert property (@(posedge clk) disable iff (!arst_n)
		result_ch.valid |-> result_ch.moving == (result_ch.moving_up || result_ch.moving_down))
		else $error("moving does not match its direction gates");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		sample_ch.valid && sample_ch.ready |=> state_q == ST_MUL1 && init_q)
		else $error("accepted item did not start the filter product");

	a_first_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		fin_go && first_q |-> fire == '0 && slope_q == '0)
		else $error("first item fired a trigger or gave a slope");

endmodule
`default_nettype wire
